>>> sv/timestamped_lru_block_table_macros.svh
// assertion macros for the timestamped lru block table
// used by the top level only, expects a clock named aclk and a reset named aresetn
`ifndef TIMESTAMPED_LRU_BLOCK_TABLE_MACROS_SVH
`define TIMESTAMPED_LRU_BLOCK_TABLE_MACROS_SVH

// property checked on every clock edge outside reset
`define TLBT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define TLBT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> sv/tlbt_pkg.sv
// shared types and constants for the timestamped lru block table
// no dependencies; used by tlbt_table and timestamped_lru_block_table
`default_nettype none

package tlbt_pkg;

    localparam int unsigned WORD_W = 32;

    // reset values of the table and the expiry register
    localparam logic [WORD_W-1:0] ID_RESET     = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] STAMP_RESET  = 32'h0000_0000;
    localparam logic [WORD_W-1:0] EXPIRY_RESET = 32'd2000;

    // width of the result tdata, padded to a whole byte
    localparam int unsigned OUT_DATA_W = 8;

    // item kinds carried on tuser
    typedef enum logic {
        KIND_QUERY = 1'b0,
        KIND_MARK  = 1'b1
    } kind_t;

    // one request as held in the input register
    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] group_id;
        logic [WORD_W-1:0] now;
    } req_t;

endpackage

`default_nettype wire

>>> sv/tlbt_table.sv
// entry table: id and stamp storage, parallel lookup, oldest-entry select and update
// depends on tlbt_pkg
`default_nettype none

module tlbt_table #(
    parameter int unsigned TABLE_ENTRIES = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          upd_en,
    input  wire tlbt_pkg::req_t                req,
    input  wire logic [tlbt_pkg::WORD_W-1:0]   expiry,
    output logic                               blocked
);

    logic [tlbt_pkg::WORD_W-1:0] ids_reg    [TABLE_ENTRIES];
    logic [tlbt_pkg::WORD_W-1:0] stamps_reg [TABLE_ENTRIES];
    logic [tlbt_pkg::WORD_W-1:0] ids_next    [TABLE_ENTRIES];
    logic [tlbt_pkg::WORD_W-1:0] stamps_next [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0]    match;
    logic [TABLE_ENTRIES-1:0]    hit_first;
    logic [TABLE_ENTRIES-1:0]    victim;
    logic                        any_hit;
    logic [tlbt_pkg::WORD_W-1:0] hit_stamp;
    logic [tlbt_pkg::WORD_W-1:0] age;

    // id compare, lowest matching entry wins
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i]     = (ids_reg[i] == req.group_id);
            hit_first[i] = match[i] & ~seen;
            seen         = seen | match[i];
        end
        any_hit = seen;
    end

    // stamp of the hit entry, one-hot select
    always_comb begin
        hit_stamp = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit_first[i]) begin
                hit_stamp = hit_stamp | stamps_reg[i];
            end
        end
    end

    // age modulo 2^32 against the expiry interval
    assign age     = req.now - hit_stamp;
    assign blocked = (req.kind == tlbt_pkg::KIND_QUERY) && any_hit && (age <= expiry);

    // oldest entry: strictly below every lower index, not above any higher one
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            victim[i] = 1'b1;
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                if (j < i) begin
                    victim[i] = victim[i] & (stamps_reg[i] < stamps_reg[j]);
                end else if (j > i) begin
                    victim[i] = victim[i] & (stamps_reg[i] <= stamps_reg[j]);
                end
            end
        end
    end

    // mark: refresh the hit entry, or replace the oldest one
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            ids_next[i]    = ids_reg[i];
            stamps_next[i] = stamps_reg[i];
            if (upd_en && (req.kind == tlbt_pkg::KIND_MARK)) begin
                if (any_hit) begin
                    if (hit_first[i]) begin
                        stamps_next[i] = req.now;
                    end
                end else if (victim[i]) begin
                    ids_next[i]    = req.group_id;
                    stamps_next[i] = req.now;
                end
            end
        end
    end

    // table storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!aresetn) begin
                ids_reg[i]    <= tlbt_pkg::ID_RESET;
                stamps_reg[i] <= tlbt_pkg::STAMP_RESET;
            end else begin
                ids_reg[i]    <= ids_next[i];
                stamps_reg[i] <= stamps_next[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/timestamped_lru_block_table.sv
// Timestamped LRU block table: a small cache of blocked group ids with expiry.
//
// Input channel s_*: one item per handshake. s_tuser carries the kind
// (query or mark), s_tdata carries group_id and now. Result channel m_*:
// one item per input item, in order; m_tdata bit 0 is blocked (always 0
// for a mark). Configuration channel cfg_*: writes the expiry interval,
// always ready; write it only while no item is in flight.
//
// An item passes the input register, then the result register, before it shows
// on m_tvalid. Throughput: one item per cycle while m_tready stays high; the
// table lookup, the oldest-entry search and the table update all sit in the
// single logic stage between the two registers, so each item sees the table
// as left by the item before it.
//
// Reset (aresetn low, synchronous): entries go to id all-ones with stamp 0,
// the expiry interval to 2000, both registers empty.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item; after that s_tready drops.
`default_nettype none

`include "timestamped_lru_block_table_macros.svh"

module timestamped_lru_block_table #(
    parameter int unsigned TABLE_ENTRIES = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input item channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [2*tlbt_pkg::WORD_W-1:0]     s_tdata,  // [31:0] group_id, [63:32] now
    input  wire logic [0:0]                        s_tuser,  // [0] kind
    // result item channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tlbt_pkg::OUT_DATA_W-1:0]        m_tdata,  // [0] blocked, [7:1] zero
    // expiry interval write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tlbt_pkg::WORD_W-1:0]       cfg_data
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    tlbt_pkg::req_t              req_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        blocked_reg;
    logic [tlbt_pkg::WORD_W-1:0] expiry_reg;
    logic                        s_accept;
    logic                        advance;
    logic                        mark_advance;
    logic                        blocked;

    // handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // valid flags and expiry register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            expiry_reg    <= tlbt_pkg::EXPIRY_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                expiry_reg <= cfg_data;
            end
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg.kind     <= tlbt_pkg::kind_t'(s_tuser[0]);
            req_reg.group_id <= s_tdata[tlbt_pkg::WORD_W-1:0];
            req_reg.now      <= s_tdata[2*tlbt_pkg::WORD_W-1:tlbt_pkg::WORD_W];
        end
    end

    // table lookup and update
    tlbt_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd_en  (advance),
        .req     (req_reg),
        .expiry  (expiry_reg),
        .blocked (blocked)
    );

    // result register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            blocked_reg <= blocked;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tlbt_pkg::OUT_DATA_W-1){1'b0}}, blocked_reg};

    // a mark item moving into the result register
    assign mark_advance = advance && (req_reg.kind == tlbt_pkg::KIND_MARK);

    // checks
    `TLBT_ASSERT(a_hold_input, in_valid_reg && !advance |=> in_valid_reg, "input item dropped")
    `TLBT_ASSERT(a_result_follows, advance |=> m_tvalid, "result missing after processing")
    `TLBT_ASSERT(a_mark_not_blocked, mark_advance |=> !m_tdata[0], "mark item reported blocked")

endmodule

`default_nettype wire
